FILE: hdl/trfd_pkg.sv
package trfd_pkg;

	// tablet type codes
	localparam logic [2:0] TYPE_NONE      = 3'd0;
	localparam logic [2:0] TYPE_LOWRES_A  = 3'd1;
	localparam logic [2:0] TYPE_LOWRES_B  = 3'd2;
	localparam logic [2:0] TYPE_TILT      = 3'd3;
	localparam logic [2:0] TYPE_SIXAXIS   = 3'd4;
	localparam logic [2:0] TYPE_LOWRES_NEW = 3'd5;
	localparam logic [2:0] TYPE_HIRES     = 3'd6;
	localparam logic [2:0] TYPE_UNUSED    = 3'd7;
	localparam logic [2:0] TYPE_RESET     = TYPE_LOWRES_A;

	// command codes (tuser)
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam int MAX_RECORD_BYTES_DEF = 17;
	localparam int DECODE_BYTES         = 17;   // highest byte position any rule reads, plus one
	localparam int PROX_BIT             = 15;
	localparam logic [15:0] PROX        = 16'(1) << PROX_BIT;
	localparam logic [6:0] KEY_SPACE    = 7'o040;
	localparam int OUT_W                = 160;

	typedef struct packed {
		logic [15:0] sample_count;
		logic [6:0]  y_tilt;
		logic [6:0]  x_tilt;
		logic [4:0]  pressure;
		logic [6:0]  key_code;
		logic [15:0] status_bits;
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] azimuth;
		logic [15:0] z_position;
		logic [15:0] y_position;
		logic [15:0] x_position;
	} held_t;

	function automatic logic [4:0] rec_size(input logic [2:0] ttype);
		logic [4:0] r;
		unique case (ttype) inside
			TYPE_LOWRES_A, TYPE_LOWRES_B, TYPE_LOWRES_NEW: r = 5'd5;
			TYPE_TILT:    r = 5'd8;
			TYPE_SIXAXIS: r = 5'd17;
			TYPE_HIRES:   r = 5'd6;
			default:      r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sync_mask(input logic [2:0] ttype);
		logic [7:0] m;
		unique case (ttype) inside
			TYPE_NONE, TYPE_UNUSED: m = 8'o000;
			TYPE_LOWRES_NEW:        m = 8'o100;
			default:                m = 8'o200;
		endcase
		return m;
	endfunction

endpackage

FILE: hdl/tablet_record_framer_decoder_unit.sv
// Channel   | Dir | Beat fields
// ----------+-----+---------------------------------------------------------------
// s_*       | in  | tuser: cmd (0 byte, 1 read); tdata: rx_byte
// m_*       | out | tdata: held record, 154 bits used, see port comment
// tablet_*  | in  | write enable + 3-bit tablet type, no handshake
//
// One beat per cycle sustained while the output is taken. A beat is held in the input
// register (_s1), where framing and decode run on fixed buffer positions; the result,
// if any, is then registered in the output register (_s2).
// Reset (arst_n low): buffer, fill count and held record clear, type = 1.
// Stall: s_tready drops only while the output register is full and not taken.
module tablet_record_framer_decoder_unit
	import trfd_pkg::*;
#(
	parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tablet_type_we,
	input  logic [2:0]        tablet_type_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] rx_byte
	input  logic [0:0]        s_tuser,   // [0] cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	// [15:0] x_position, [31:16] y_position, [47:32] z_position,
	// [63:48] azimuth, [79:64] pitch, [95:80] roll, [111:96] status_bits,
	// [118:112] key_code, [123:119] pressure, [130:124] x_tilt,
	// [137:131] y_tilt, [153:138] sample_count, [159:154] zero
	output logic [OUT_W-1:0]  m_tdata
);

	// ---- state ----
	logic [2:0]  type_q;
	logic [4:0]  fill_q;
	logic [6:0]  rec_q [MAX_RECORD_BYTES];
	held_t       held_q;

	// input register
	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;

	// output register
	logic             valid_s2;
	logic [OUT_W-1:0] data_s2;

	// ---- control ----
	logic        out_free, fire, is_byte, complete, result_en;
	logic [4:0]  rs, f0, fill_nx;
	logic        sync_hit;
	logic [MAX_RECORD_BYTES-1:0] wr_sel;
	logic [6:0]  b [DECODE_BYTES];   // record as seen with the current byte written
	held_t       held_dec, held_out;

	assign out_free = !valid_s2 || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign rs       = rec_size(type_q);
	assign is_byte  = fire && (cmd_s1 == CMD_BYTE) && (rs != 5'd0);
	assign sync_hit = (byte_s1 & sync_mask(type_q)) != 8'd0;
	// sync byte, full record, or fill beyond size after a type change: restart
	assign f0       = (sync_hit || fill_q >= rs) ? 5'd0 : fill_q;
	assign fill_nx  = f0 + 5'd1;
	assign complete = (fill_nx == rs);
	assign result_en = fire && ((cmd_s1 == CMD_READ) || (is_byte && complete));

	always_comb begin
		for (int i = 0; i < MAX_RECORD_BYTES; i++) begin
			wr_sel[i] = is_byte && (f0 == 5'(i));
		end
	end

	// positions past the buffer read as zero
	for (genvar gi = 0; gi < DECODE_BYTES; gi++) begin : g_view
		if (gi < MAX_RECORD_BYTES) begin : g_have
			assign b[gi] = wr_sel[gi] ? byte_s1[6:0] : rec_q[gi];
		end else begin : g_none
			assign b[gi] = 7'd0;
		end
	end

	// ---- decode ----
	logic [5:0]  v6;
	logic [3:0]  bidx;
	logic [13:0] x14;
	logic [15:0] st;

	always_comb begin
		held_dec = held_q;
		v6   = b[0][5:0];
		bidx = (v6 < 6'd32) ? 4'd0 : v6[4:1];
		x14  = {b[1], b[2]};
		st   = b[0][6] ? PROX : 16'd0;
		if (v6 > 6'd30) st = st | (16'd1 << bidx);
		if (x14 < 14'd256) st = st & ~PROX;
		case (type_q) inside
			TYPE_LOWRES_A, TYPE_LOWRES_B: begin
				held_dec.x_position   = {2'b00, x14};
				held_dec.y_position   = {2'b00, b[3], b[4]};
				held_dec.status_bits  = st;
				held_dec.sample_count = held_q.sample_count + 16'd1;
			end
			TYPE_TILT: begin
				held_dec.pressure     = b[0][6:2];
				held_dec.status_bits  = {15'd0, b[0][6:2] > 5'd16} | PROX;
				held_dec.x_position   = {b[0][1:0], b[1], b[2]};
				held_dec.y_position   = {b[3][1:0], b[4], b[5]};
				held_dec.x_tilt       = b[6];
				held_dec.y_tilt       = b[7];
				held_dec.sample_count = held_q.sample_count + 16'd1;
			end
			TYPE_SIXAXIS: begin
				held_dec.x_position = {2'b00, b[3], b[4]} | {b[9][1:0], 14'd0};
				held_dec.y_position = {2'b00, b[5], b[6]} | {b[9][3:2], 14'd0};
				held_dec.z_position = {2'b00, b[7], b[8]} | {b[9][5:4], 14'd0};
				held_dec.azimuth    = {2'b00, b[10], b[11]} | {b[16][1:0], 14'd0};
				held_dec.pitch      = {2'b00, b[12], b[13]} | {b[16][3:2], 14'd0};
				held_dec.roll       = {2'b00, b[14], b[15]} | {b[16][5:4], 14'd0};
				held_dec.status_bits = {2'b00, b[0], b[1]};
				if (b[2] != KEY_SPACE) held_dec.key_code = b[2];
			end
			TYPE_LOWRES_NEW: begin
				held_dec.status_bits  = {12'd0, b[0][5:2]} | PROX;
				held_dec.x_position   = {3'd0, b[2], 6'd0} | {9'd0, b[1]};
				held_dec.y_position   = {3'd0, b[4], 6'd0} | {9'd0, b[3]};
				held_dec.sample_count = held_q.sample_count + 16'd1;
			end
			TYPE_HIRES: begin
				held_dec.x_position   = {b[0][1:0], b[1], b[2]};
				held_dec.y_position   = {b[3][1:0], b[4], b[5]};
				held_dec.status_bits  = {11'd0, b[0][6:2]} | PROX;
				held_dec.sample_count = held_q.sample_count + 16'd1;
			end
			default: begin
			end
		endcase
	end

	assign held_out = (cmd_s1 == CMD_READ) ? held_q : held_dec;

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= TYPE_RESET;
			fill_q   <= 5'd0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < MAX_RECORD_BYTES; i++) rec_q[i] <= 7'd0;
		end else begin
			if (tablet_type_we) type_q <= tablet_type_wdata;

			if (s_tready) valid_s1 <= s_tvalid;

			if (fire) valid_s2 <= result_en;
			else if (m_tready) valid_s2 <= 1'b0;

			if (is_byte) fill_q <= fill_nx;
			for (int i = 0; i < MAX_RECORD_BYTES; i++) begin
				if (wr_sel[i]) rec_q[i] <= byte_s1[6:0];
			end

			if (fire && cmd_s1 == CMD_READ) begin
				if (type_q == TYPE_SIXAXIS) held_q.key_code <= KEY_SPACE;
			end else if (is_byte && complete) begin
				held_q <= held_dec;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
		if (result_en) data_s2 <= OUT_W'(held_out);
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef NO_ASSERTIONS
	// a read always yields a beat on the next edge
	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1 == CMD_READ |=> m_tvalid)
		else $error("read command produced no result");

	// sample count moves by at most one per processed beat
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (held_q.sample_count == $past(held_q.sample_count)) ||
			(held_q.sample_count == $past(held_q.sample_count) + 16'd1))
		else $error("sample count jumped");

	// with no tablet type, received bytes leave framing state alone
	a_none_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_s1 == CMD_BYTE && (type_q == TYPE_NONE || type_q == TYPE_UNUSED)
		|=> $stable(fill_q) && $stable(held_q) && !m_tvalid)
		else $error("byte processed with no tablet type");
`endif

endmodule

FILE: sim/tb.sv
`default_nettype none

module tb;
	import trfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_HOLD_CYCLES = 200;   // long receiver hold-off for the backpressure test
	localparam int DRAIN_CYCLES   = 4;     // pipeline is 2 deep; a little slack on top

	logic              clk;
	logic              arst_n;
	logic              tablet_type_we;
	logic [2:0]        tablet_type_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] rx_byte
	logic [0:0]        s_tuser;   // [0] cmd
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // held_t in [153:0], zero above

	tablet_record_framer_decoder_unit DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.tablet_type_we    (tablet_type_we),
		.tablet_type_wdata (tablet_type_wdata),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata)
	);

	// ---------------------------------------------------------------
	// Shadow copy of the framer: byte buffer, fill count, held record
	// and the active tablet type. Updated on every accepted input beat.
	// ---------------------------------------------------------------
	logic [6:0]  rec_bytes_m [17];
	logic [4:0]  fill_m;
	held_t       held_m;
	logic [2:0]  ttype_m;

	held_t       pending_records [$];   // held records still owed on the output side
	int          fail_count;
	int          beats_counted;         // beats that do something (ignored bytes excluded)
	bit          quiet;                 // no idling on either side while set
	bit          hold_pending;          // asks the receiver for one long hold-off

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// bytes per record for each tablet type; 0 means bytes are dropped
	function automatic logic [4:0] record_len(input logic [2:0] t);
		case (t)
			TYPE_TILT:              return 5'd8;
			TYPE_SIXAXIS:           return 5'd17;
			TYPE_HIRES:             return 5'd6;
			TYPE_NONE, TYPE_UNUSED: return 5'd0;
			default:                return 5'd5;
		endcase
	endfunction

	// start-of-record marker bit
	function automatic logic [7:0] sync_bit(input logic [2:0] t);
		return (t == TYPE_LOWRES_NEW) ? 8'h40 : 8'h80;
	endfunction

	// Apply the type-specific decode to the full record in the shadow buffer.
	// Only the fields a type produces are touched; the rest keep their value.
	function automatic void decode_record();
		logic [15:0] st;
		logic [5:0]  v;
		logic [13:0] x14;
		case (ttype_m)
			TYPE_LOWRES_A, TYPE_LOWRES_B: begin
				st = rec_bytes_m[0][6] ? PROX : 16'h0;
				v  = rec_bytes_m[0][5:0];
				// button code: 31 -> bit 0, 32..63 -> bit (v-32)/2
				if (v >= 6'd32)
					st[v[4:1]] = 1'b1;
				else if (v == 6'd31)
					st[0] = 1'b1;
				x14 = {rec_bytes_m[1], rec_bytes_m[2]};
				if (x14 < 14'd256)
					st = st & ~PROX;   // pen out of range near the origin
				held_m.x_position   = 16'(x14);
				held_m.y_position   = 16'({rec_bytes_m[3], rec_bytes_m[4]});
				held_m.status_bits  = st;
				held_m.sample_count = held_m.sample_count + 16'd1;
			end
			TYPE_TILT: begin
				held_m.pressure     = rec_bytes_m[0][6:2];
				held_m.status_bits  = PROX | 16'(held_m.pressure > 5'd16);
				held_m.x_position   = {rec_bytes_m[0][1:0], rec_bytes_m[1], rec_bytes_m[2]};
				held_m.y_position   = {rec_bytes_m[3][1:0], rec_bytes_m[4], rec_bytes_m[5]};
				held_m.x_tilt       = rec_bytes_m[6];
				held_m.y_tilt       = rec_bytes_m[7];
				held_m.sample_count = held_m.sample_count + 16'd1;
			end
			TYPE_SIXAXIS: begin
				// bytes 9 and 16 carry the two top bits of three axes each
				held_m.x_position  = {rec_bytes_m[9][1:0], rec_bytes_m[3], rec_bytes_m[4]};
				held_m.y_position  = {rec_bytes_m[9][3:2], rec_bytes_m[5], rec_bytes_m[6]};
				held_m.z_position  = {rec_bytes_m[9][5:4], rec_bytes_m[7], rec_bytes_m[8]};
				held_m.azimuth     = {rec_bytes_m[16][1:0], rec_bytes_m[10], rec_bytes_m[11]};
				held_m.pitch       = {rec_bytes_m[16][3:2], rec_bytes_m[12], rec_bytes_m[13]};
				held_m.roll        = {rec_bytes_m[16][5:4], rec_bytes_m[14], rec_bytes_m[15]};
				held_m.status_bits = 16'({rec_bytes_m[0], rec_bytes_m[1]});
				if (rec_bytes_m[2] != KEY_SPACE)
					held_m.key_code = rec_bytes_m[2];
			end
			TYPE_LOWRES_NEW: begin
				held_m.status_bits  = PROX | 16'(rec_bytes_m[0][5:2]);
				held_m.x_position   = 16'(rec_bytes_m[1]) | (16'(rec_bytes_m[2]) << 6);
				held_m.y_position   = 16'(rec_bytes_m[3]) | (16'(rec_bytes_m[4]) << 6);
				held_m.sample_count = held_m.sample_count + 16'd1;
			end
			TYPE_HIRES: begin
				held_m.x_position   = {rec_bytes_m[0][1:0], rec_bytes_m[1], rec_bytes_m[2]};
				// y top byte shifted by 14: only its low 2 bits survive
				held_m.y_position   = {rec_bytes_m[3][1:0], rec_bytes_m[4], rec_bytes_m[5]};
				held_m.status_bits  = PROX | 16'(rec_bytes_m[0][6:2]);
				held_m.sample_count = held_m.sample_count + 16'd1;
			end
			default: ;
		endcase
	endfunction

	// One accepted input beat. Returns 1 and the record when a result beat is owed.
	function automatic bit frame_beat(input logic cmd, input logic [7:0] b, output held_t rec);
		logic [4:0] len;
		rec = held_m;
		if (cmd == CMD_READ) begin
			if (ttype_m == TYPE_SIXAXIS)
				held_m.key_code = KEY_SPACE;   // key is consumed by the read
			return 1'b1;
		end
		len = record_len(ttype_m);
		if (len == 5'd0)
			return 1'b0;
		// restart on marker, or when the count already covers a record
		if ((b & sync_bit(ttype_m)) != 8'h0 || fill_m >= len)
			fill_m = 5'd0;
		if (fill_m < 5'd17)
			rec_bytes_m[fill_m] = b[6:0];
		fill_m = fill_m + 5'd1;
		if (fill_m == len) begin
			decode_record();
			rec = held_m;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one beat from the falling edge, wait for the handshake, then update the shadow.
	task automatic send_beat(input logic cmd, input logic [7:0] b);
		held_t rec;
		while (!quiet && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_READ || record_len(ttype_m) != 5'd0)
			beats_counted++;
		if (frame_beat(cmd, b, rec))
			pending_records.push_back(rec);
		@(negedge clk);
	endtask

	// Stop offering and let every owed beat come out plus the pipeline depth.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_records.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_tablet_type(input logic [2:0] t);
		drain();
		tablet_type_we    <= 1'b1;
		tablet_type_wdata <= t;
		@(negedge clk);
		tablet_type_we    <= 1'b0;
		ttype_m = t;
	endtask

	// marker byte, then n-1 copies of the body byte
	task automatic send_fixed(input logic [7:0] first, input logic [7:0] body, input int n);
		send_beat(CMD_BYTE, first);
		for (int i = 1; i < n; i++)
			send_beat(CMD_BYTE, body);
	endtask

	// Random record for the current type; a broken one stops short.
	task automatic send_record(input bit broken);
		logic [4:0] len;
		logic [7:0] sb;
		logic [7:0] b;
		int         n;
		len = record_len(ttype_m);
		sb  = sync_bit(ttype_m);
		n   = broken ? $urandom_range(len - 1, 1) : len;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			b = (i == 0) ? (b | sb) : (b & ~sb);
			// bias toward the key-kept and near-origin corners
			if (i == 2 && ttype_m == TYPE_SIXAXIS && $urandom_range(3) == 0)
				b = {1'b0, KEY_SPACE};
			if (i == 1 && (ttype_m == TYPE_LOWRES_A || ttype_m == TYPE_LOWRES_B)
					&& $urandom_range(3) == 0)
				b = 8'h00;
			send_beat(CMD_BYTE, b);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// held record is all zero after reset; reset type is the five-byte one
	task automatic test_reset_values();
		send_beat(CMD_READ, 8'h00);
		send_fixed(8'hFF, 8'h7F, 5);
	endtask

	// button decode and the near-origin proximity drop
	task automatic test_lowres_buttons();
		send_fixed(8'hDF, 8'h00, 5);   // button code 31, x below 256
		send_fixed(8'hDE, 8'h7F, 5);   // code 30: no button
		send_beat(CMD_READ, 8'hFF);
	endtask

	// no type selected: bytes dropped, reads still answered
	task automatic test_no_type();
		load_tablet_type(TYPE_NONE);
		send_beat(CMD_BYTE, 8'hFF);
		send_beat(CMD_READ, 8'h00);
		load_tablet_type(TYPE_UNUSED);
		send_beat(CMD_BYTE, 8'h80);
		send_beat(CMD_READ, 8'h00);
	endtask

	task automatic test_each_format();
		load_tablet_type(TYPE_TILT);
		send_fixed(8'h80, 8'h00, 8);   // pressure 0
		send_fixed(8'hFF, 8'h7F, 8);   // pressure 31
		load_tablet_type(TYPE_LOWRES_NEW);
		send_fixed(8'hFF, 8'hBF, 5);   // bit 7 set without being a marker
		load_tablet_type(TYPE_HIRES);
		send_fixed(8'hFF, 8'h7F, 6);
		load_tablet_type(TYPE_SIXAXIS);
		send_fixed(8'hFF, 8'h7F, 17);
		send_beat(CMD_READ, 8'h00);
		send_beat(CMD_READ, 8'h00);    // key now space
	endtask

	// type change mid-record leaves the fill past the new record size
	task automatic test_fill_overrun();
		send_fixed(8'h81, 8'h15, 10);
		load_tablet_type(TYPE_HIRES);
		send_fixed(8'h2A, 8'h55, 6);   // first byte restarts with no marker
	endtask

	// receiver stops for a long time; the sender keeps offering until the input stalls
	task automatic test_backpressure();
		load_tablet_type(TYPE_LOWRES_A);
		hold_pending = 1'b1;
		for (int i = 0; i < 30; i++)
			send_beat(CMD_READ, 8'($urandom_range(255)));
		for (int i = 0; i < 4; i++)
			send_record(1'b0);
	endtask

	task automatic run_random_phase(input logic [2:0] t, input int n_beats);
		int start;
		int r;
		load_tablet_type(t);
		start = beats_counted;
		while (beats_counted - start < n_beats) begin
			r = $urandom_range(99);
			if (record_len(ttype_m) == 5'd0) begin
				if (r < 60)
					send_beat(CMD_READ, 8'($urandom_range(255)));
				else
					send_beat(CMD_BYTE, 8'($urandom_range(255)));
			end else if (r < 70) begin
				send_record(1'b0);
			end else if (r < 80) begin
				send_record(1'b1);
			end else if (r < 88) begin
				send_beat(CMD_READ, 8'($urandom_range(255)));
			end else begin
				send_beat(CMD_BYTE, 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_random();
		logic [2:0] seq [13] = '{TYPE_SIXAXIS, TYPE_NONE, TYPE_TILT, TYPE_HIRES, TYPE_LOWRES_A,
			TYPE_LOWRES_NEW, TYPE_UNUSED, TYPE_LOWRES_B, TYPE_SIXAXIS, TYPE_TILT,
			TYPE_HIRES, TYPE_LOWRES_NEW, TYPE_LOWRES_A};
		for (int p = 0; p < 13; p++) begin
			quiet = (p == 4);   // one long stretch with no idling at all
			run_random_phase(seq[p], (record_len(seq[p]) == 5'd0) ? 40 : 150);
		end
		quiet = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stalls, or one long hold-off counted here
	// ---------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				for (int k = 0; k < RX_HOLD_CYCLES; k++) begin
					m_tready <= 1'b0;
					@(negedge clk);
				end
				hold_pending = 1'b0;
			end
			m_tready <= quiet || ($urandom_range(99) >= 11);
		end
	end

	// ---------------------------------------------------------------
	// Output check: every result beat against the oldest owed record
	// ---------------------------------------------------------------
	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		held_t got;
		held_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = held_t'(m_tdata[153:0]);
			if (pending_records.size() == 0) begin
				$error("result beat with no record owed");
				fail_count++;
			end else begin
				want = pending_records.pop_front();
				check_field("x_position",   want.x_position,   got.x_position);
				check_field("y_position",   want.y_position,   got.y_position);
				check_field("z_position",   want.z_position,   got.z_position);
				check_field("azimuth",      want.azimuth,      got.azimuth);
				check_field("pitch",        want.pitch,        got.pitch);
				check_field("roll",         want.roll,         got.roll);
				check_field("status_bits",  want.status_bits,  got.status_bits);
				check_field("key_code",     16'(want.key_code), 16'(got.key_code));
				check_field("pressure",     16'(want.pressure), 16'(got.pressure));
				check_field("x_tilt",       16'(want.x_tilt),   16'(got.x_tilt));
				check_field("y_tilt",       16'(want.y_tilt),   16'(got.y_tilt));
				check_field("sample_count", want.sample_count, got.sample_count);
				check_field("tdata_pad",    16'h0,             16'(m_tdata[OUT_W-1:154]));
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#400_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = 8'h00;
		s_tuser           = CMD_BYTE;
		tablet_type_we    = 1'b0;
		tablet_type_wdata = TYPE_NONE;
		quiet             = 1'b0;
		hold_pending      = 1'b0;
		fail_count        = 0;
		beats_counted     = 0;
		for (int i = 0; i < 17; i++)
			rec_bytes_m[i] = 7'h0;
		fill_m  = 5'd0;
		held_m  = '0;
		ttype_m = TYPE_RESET;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_lowres_buttons();
		test_no_type();
		test_each_format();
		test_fill_overrun();
		test_backpressure();
		test_random();

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/trfd_pkg.sv
hdl/tablet_record_framer_decoder_unit.sv
sim/tb.sv
